/* rtl/core/tdpb_pkg.sv */
// Package of the tail-drop packet buffer.
// Holds the default sizes, the register map and the cell control type.
// It has no dependencies.
package tdpb_pkg;

	localparam int DEPTH_DEF     = 256;
	localparam int TIME_BITS_DEF = 32;

	localparam int                  BUF_SIZE_W     = 9;
	localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_RESET = 9'd256;

	localparam int         PADDR_W          = 3;
	localparam logic [0:0] REG_BUFFER_SIZE  = 1'b0;

	localparam int ARRIVAL_W = 32;
	localparam int PROC_W    = 16;
	localparam int START_W   = 32;

	typedef struct packed {
		logic shift;
		logic push;
	} cell_ctrl_t;

endpackage

/* rtl/core/tdpb_cell.sv */
// One storage cell of the finish-time queue.
// It takes its upper neighbor's value on a shift or a new value on a push.
// Depends on tdpb_pkg.
module tdpb_cell #(
	parameter int TIME_BITS = 32,
	parameter int CNT_W     = 9,
	parameter int IDX       = 0
) (
	input  logic                  clk,
	input  tdpb_pkg::cell_ctrl_t  ctrl,
	input  logic [CNT_W-1:0]      occupancy,
	input  logic [TIME_BITS-1:0]  next_value,
	input  logic [TIME_BITS-1:0]  push_value,
	output logic [TIME_BITS-1:0]  value
);
	import tdpb_pkg::*;

	logic [TIME_BITS-1:0] value_q;
	logic                 hit;

	assign hit   = (occupancy == CNT_W'(IDX));
	assign value = value_q;

	always_ff @(posedge clk) begin
		if (ctrl.push && hit) begin
			value_q <= push_value;
		end else if (ctrl.shift) begin
			value_q <= next_value;
		end
	end

endmodule

/* rtl/core/tail_drop_packet_buffer.sv */
// Top level of the tail-drop packet buffer: sequencer, counters and the cell row.
// Depends on tdpb_pkg and tdpb_cell.
//
// A packet enters on the s_ channel (arrival and processing time in s_tdata,
// end of batch on s_tlast) and leaves one transaction on the m_ channel with
// the start time in m_tdata and the drop flag in m_tuser.
// The queue of finish times is a row of cells; the head sits in cell 0 and
// every retirement shifts the whole row down by one cell.
// A new packet is accepted only after the current one has retired its k expired
// packets, one per cycle through the head compare, and passed the decision step;
// m_tvalid rises in the cycle after that decision step, which follows the last
// retire step.
// The capacity register lies at byte address 0 of the APB port; pready is
// always high. Reset empties the queue and sets the capacity to 256.
// While the receiver stalls, the result waits in the output register and the
// input is already open for the next packet; that packet waits in the head
// compare step until the output register is free.
module tail_drop_packet_buffer #(
	parameter int DEPTH     = tdpb_pkg::DEPTH_DEF,
	parameter int TIME_BITS = tdpb_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [47:0]                   s_tdata,   // arrival_ts, service_len
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,   // start_time
	output logic                          m_tuser,   // dropped
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tdpb_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import tdpb_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CW    = (CNT_W > BUF_SIZE_W) ? CNT_W : BUF_SIZE_W;
	localparam int SW    = ((TIME_BITS > PROC_W) ? TIME_BITS : PROC_W) + 1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        occ_q;
	logic [TIME_BITS-1:0]    last_finish_q;
	logic [TIME_BITS-1:0]    arr_q;
	logic [PROC_W-1:0]       proc_q;
	logic                    eob_q;
	logic [BUF_SIZE_W-1:0]   buffer_size_q;
	logic                    m_tvalid_q;
	logic [START_W-1:0]      m_tdata_q;
	logic                    m_tuser_q;

	logic [TIME_BITS-1:0]    cell_value [DEPTH];
	logic [TIME_BITS-1:0]    head;
	logic                    retire;
	logic                    out_free;
	logic                    decide;
	logic                    drop;
	logic [TIME_BITS-1:0]    start;
	logic [SW-1:0]           sum;
	logic [TIME_BITS-1:0]    fin;
	cell_ctrl_t              ctrl;
	logic                    cfg_wr;

	assign head     = cell_value[0];
	assign retire   = (state_q == ST_RUN) && (occ_q != '0) && (arr_q >= head);
	assign out_free = !m_tvalid_q || m_tready;
	assign decide   = (state_q == ST_RUN) && !retire && out_free;
	assign drop     = (occ_q == CNT_W'(DEPTH)) || (CW'(occ_q) >= CW'(buffer_size_q));
	assign start    = (occ_q != '0) ? last_finish_q : arr_q;
	assign sum      = SW'(start) + SW'(proc_q);
	assign fin      = (|sum[SW-1:TIME_BITS]) ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

	assign ctrl.shift = retire;
	assign ctrl.push  = decide && !drop;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [TIME_BITS-1:0] nb;
			if (gi == DEPTH - 1) begin : g_top
				assign nb = cell_value[gi];
			end else begin : g_mid
				assign nb = cell_value[gi+1];
			end
			tdpb_cell #(
				.TIME_BITS (TIME_BITS),
				.CNT_W     (CNT_W),
				.IDX       (gi)
			) u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.occupancy  (occ_q),
				.next_value (nb),
				.push_value (fin),
				.value      (cell_value[gi])
			);
		end
	endgenerate

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1] == REG_BUFFER_SIZE) ? 32'(buffer_size_q) : 32'd0;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			arr_q  <= TIME_BITS'(s_tdata[ARRIVAL_W-1:0]);
			proc_q <= s_tdata[ARRIVAL_W+PROC_W-1:ARRIVAL_W];
			eob_q  <= s_tlast;
		end
		if (decide) begin
			m_tdata_q <= drop ? '0 : START_W'(start);
			m_tuser_q <= drop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			occ_q         <= '0;
			last_finish_q <= '0;
			buffer_size_q <= BUF_SIZE_RESET;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_wr && (paddr[PADDR_W-1] == REG_BUFFER_SIZE)) begin
				buffer_size_q <= pwdata[BUF_SIZE_W-1:0];
			end
			if (m_tvalid_q && m_tready && !decide) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (retire) begin
						occ_q <= occ_q - 1'b1;
					end else if (decide) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
						if (eob_q) begin
							occ_q         <= '0;
							last_finish_q <= '0;
						end else if (!drop) begin
							occ_q         <= occ_q + 1'b1;
							last_finish_q <= fin;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(DEPTH))
		else $error("queue occupancy exceeds the number of cells");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |-> (occ_q != CNT_W'(DEPTH)) && !ctrl.shift)
		else $error("push into a full cell row or during a shift");

	a_batch_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(decide && eob_q) |=> (occ_q == '0) && (last_finish_q == '0))
		else $error("queue not emptied after the end of a batch");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		decide |=> m_tvalid_q && (state_q == ST_IDLE))
		else $error("decision step did not load a result");
`endif

endmodule

/* tb/sv/tb_tail_drop_packet_buffer.sv */
// Testbench of tail_drop_packet_buffer: directed and random packets checked against an
// in-bench model of the tail-drop queue. Depends on tdpb_pkg and the RTL of the block.
module tb_tail_drop_packet_buffer;
	timeunit 1ns;
	timeprecision 1ps;

	import tdpb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_GAP     = 13;
	localparam int REG_SPARE   = 1;

	typedef struct {
		bit [ARRIVAL_W-1:0] arrival;
		bit [PROC_W-1:0]    proc;
		bit                 eob;
		int                 gap;
	} packet_t;

	typedef struct {
		bit               dropped;
		bit [START_W-1:0] start;
	} verdict_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [47:0]        s_tdata  = '0;  // arrival_ts, service_len
	logic               s_tlast  = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [31:0]        m_tdata;        // start_time
	logic               m_tuser;        // dropped
	logic               psel     = 1'b0;
	logic               penable  = 1'b0;
	logic               pwrite   = 1'b0;
	logic [PADDR_W-1:0] paddr    = '0;
	logic [31:0]        pwdata   = '0;
	logic [31:0]        prdata;
	logic               pready;

	packet_t  pending_packets[$];
	verdict_t expected_verdicts[$];
	bit [ARRIVAL_W-1:0] finish_times[$];
	bit [ARRIVAL_W-1:0] newest_finish = '0;
	bit [BUF_SIZE_W-1:0] capacity = BUF_SIZE_RESET;

	packet_t staged;
	bit      have_staged = 1'b0;
	int      gap_left    = 0;
	bit      rx_calm     = 1'b0;
	int      rx_wait     = 0;
	int      rx_draw;
	int      fail_count  = 0;
	int      cycle_count = 0;

	tail_drop_packet_buffer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #4 clk = ~clk;

	function automatic verdict_t serve_packet(packet_t pkt);
		verdict_t           v;
		bit [BUF_SIZE_W-1:0] cap;
		bit [ARRIVAL_W:0]   sum;
		cap = (capacity > BUF_SIZE_W'(DEPTH_DEF)) ? BUF_SIZE_W'(DEPTH_DEF) : capacity;
		while (finish_times.size() != 0 && pkt.arrival >= finish_times[0])
			void'(finish_times.pop_front());
		if (finish_times.size() >= cap) begin
			v.dropped = 1'b1;
			v.start   = '0;
		end else begin
			v.dropped = 1'b0;
			v.start   = (finish_times.size() != 0) ? newest_finish : pkt.arrival;
			sum = {1'b0, v.start} + pkt.proc;
			newest_finish = sum[ARRIVAL_W] ? '1 : sum[ARRIVAL_W-1:0];
			finish_times.push_back(newest_finish);
		end
		if (pkt.eob) begin
			finish_times.delete();
			newest_finish = '0;
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (!have_staged && pending_packets.size() != 0) begin
				staged      = pending_packets.pop_front();
				have_staged = 1'b1;
				gap_left    = staged.gap;
			end
			if (have_staged && gap_left == 0) begin
				s_tvalid    <= 1'b1;
				s_tdata     <= {staged.proc, staged.arrival};
				s_tlast     <= staged.eob;
				have_staged = 1'b0;
			end else begin
				s_tvalid <= 1'b0;
				if (have_staged)
					gap_left = gap_left - 1;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait  <= 0;
		end else if (m_tvalid && m_tready) begin
			rx_draw  = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
			rx_wait  <= rx_draw;
			m_tready <= (rx_draw == 0);
		end else if (!m_tready) begin
			if (rx_wait <= 1)
				m_tready <= 1'b1;
			rx_wait <= rx_wait - 1;
		end
	end

	always @(posedge clk) begin
		packet_t  seen;
		verdict_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_verdicts.size() == 0) begin
					$error("result without a pending packet: dropped %0b, start_time %0h",
						m_tuser, m_tdata);
					fail_count++;
				end else begin
					want = expected_verdicts.pop_front();
					if (m_tuser !== want.dropped) begin
						$error("dropped: expected %0b, actual %0b", want.dropped, m_tuser);
						fail_count++;
					end
					if (m_tdata !== want.start) begin
						$error("start_time: expected %0h, actual %0h", want.start, m_tdata);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				seen.arrival = s_tdata[ARRIVAL_W-1:0];
				seen.proc    = s_tdata[ARRIVAL_W +: PROC_W];
				seen.eob     = s_tlast;
				seen.gap     = 0;
				expected_verdicts.push_back(serve_packet(seen));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tail_drop_packet_buffer: mismatch");
			$finish;
		end
	end

	task automatic queue_packet(bit [31:0] arrival, bit [15:0] proc, bit eob, bit quiet);
		packet_t pkt;
		pkt.arrival = arrival;
		pkt.proc    = proc;
		pkt.eob     = eob;
		pkt.gap     = quiet ? 0 : $urandom_range(0, MAX_GAP);
		pending_packets.push_back(pkt);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_packets.size() != 0 || have_staged || s_tvalid
			|| expected_verdicts.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_capacity();
		logic [31:0] seen;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= PADDR_W'(4 * int'(REG_BUFFER_SIZE));
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		seen = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (seen !== 32'(capacity)) begin
			$error("buffer_size: expected %0d, actual %0d", capacity, seen);
			fail_count++;
		end
	endtask

	task automatic set_register(int index, bit [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * index);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (index == int'(REG_BUFFER_SIZE))
			capacity = value[BUF_SIZE_W-1:0];
		check_capacity();
	endtask

	task automatic set_capacity(int cap);
		bit [31:0] word;
		word = $urandom;
		word[BUF_SIZE_W-1:0] = BUF_SIZE_W'(cap);
		set_register(int'(REG_BUFFER_SIZE), word);
	endtask

	task automatic random_phase(int count);
		bit [31:0] t;
		int        n;
		int        batch_len;
		int        inc_max;
		int        proc_max;
		bit        quiet;
		t = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20);
		n = 0;
		while (n < count) begin
			batch_len = $urandom_range(1, 120);
			quiet     = ($urandom_range(0, 3) == 0);
			inc_max   = 1 << $urandom_range(0, 16);
			proc_max  = (1 << $urandom_range(0, 16)) - 1;
			for (int i = 0; i < batch_len && n < count; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					queue_packet($urandom, 16'($urandom_range(0, 65535)),
						1'($urandom_range(0, 1)), quiet);
				end else begin
					t = t + $urandom_range(0, inc_max);
					queue_packet(t, 16'($urandom_range(0, proc_max)), i == batch_len - 1, quiet);
				end
				n++;
			end
		end
	endtask

	initial begin
		bit [31:0] base;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		check_capacity();

		rx_calm = 1'b0;
		queue_packet(32'd0, 16'd0, 1'b0, 1'b0);
		queue_packet(32'd0, 16'hFFFF, 1'b0, 1'b0);
		queue_packet(32'd5, 16'd1, 1'b0, 1'b0);
		queue_packet(32'hFFFF_FFF0, 16'hFFFF, 1'b0, 1'b0);
		queue_packet(32'hFFFF_FFF0, 16'd5, 1'b0, 1'b0);
		queue_packet(32'hFFFF_FFFF, 16'd0, 1'b1, 1'b0);
		queue_packet(32'd100, 16'd50, 1'b0, 1'b0);
		queue_packet(32'd90, 16'd10, 1'b0, 1'b0);
		queue_packet(32'd80, 16'd0, 1'b1, 1'b0);
		wait_idle();

		set_capacity(1);
		queue_packet(32'd1000, 16'd10, 1'b0, 1'b1);
		queue_packet(32'd1005, 16'd3, 1'b0, 1'b1);
		queue_packet(32'd1010, 16'd2, 1'b0, 1'b1);
		wait_idle();
		set_capacity(3);
		for (int i = 0; i < 3; i++)
			queue_packet(32'd2000, 16'd100, 1'b0, 1'b0);
		wait_idle();
		set_capacity(1);
		queue_packet(32'd2150, 16'd7, 1'b0, 1'b0);
		queue_packet(32'd2300, 16'd1, 1'b1, 1'b0);
		wait_idle();

		set_capacity(0);
		queue_packet(32'd3000, 16'd1, 1'b0, 1'b0);
		wait_idle();
		set_register(REG_SPARE, 32'h0000_01FF);
		queue_packet(32'd3001, 16'd1, 1'b0, 1'b0);
		wait_idle();
		set_capacity(511);
		queue_packet(32'd3002, 16'd2, 1'b0, 1'b0);
		queue_packet(32'd3002, 16'd2, 1'b1, 1'b0);
		wait_idle();

		for (int phase = 0; phase < 10; phase++) begin
			rx_calm = ($urandom_range(0, 3) == 0);
			if (phase == 4) begin
				set_capacity(DEPTH_DEF);
				base = $urandom_range(0, 1000);
				for (int i = 0; i < DEPTH_DEF + 14; i++)
					queue_packet(base, 16'($urandom_range(1, 65535)), 1'b0, rx_calm);
				queue_packet(32'hFFFF_FFFF, 16'($urandom_range(0, 65535)), 1'b1, 1'b0);
			end else begin
				case ($urandom_range(0, 5))
					0: set_capacity($urandom_range(1, 4));
					1: set_capacity($urandom_range(5, 32));
					2: set_capacity(DEPTH_DEF);
					3: set_capacity($urandom_range(DEPTH_DEF + 1, 511));
					4: set_capacity(0);
					default: set_capacity($urandom_range(0, 511));
				endcase
				random_phase(40);
			end
			wait_idle();
		end

		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("tail_drop_packet_buffer: match");
		else
			$display("tail_drop_packet_buffer: mismatch");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/tdpb_pkg.sv
rtl/core/tdpb_cell.sv
rtl/core/tail_drop_packet_buffer.sv
tb/sv/tb_tail_drop_packet_buffer.sv
